[design/a85_pkg.sv]
// Shared types and constants for the ASCII85 stream encoder.
package a85_pkg;

    localparam int unsigned DIGITS      = 5;
    localparam logic [6:0]  CHAR_OFFSET = 7'd33;
    localparam logic [6:0]  CHAR_MAX    = 7'd117;
    localparam logic [6:0]  NEWLINE     = 7'd10;
    localparam logic [6:0]  RADIX       = 7'd85;

    // floor(v / 85) == (v * DIV85_MAGIC) >> DIV85_SHIFT for every 32-bit v
    localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
    localparam int unsigned DIV85_SHIFT = 38;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [6:0] digit_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
    } out_item_t;

    // One unit of work for the back end: an optional group, an optional newline.
    typedef struct packed {
        logic [31:0] value;
        logic        has_group;
        logic        has_nl;
    } job_t;

    // Converted group, digit[0] is the most significant digit.
    typedef struct packed {
        digit_t [DIGITS-1:0] digit;
        logic                has_group;
        logic                has_nl;
    } group_t;

endpackage

[design/a85_front.sv]
// Front end: gathers bytes into 32-bit groups and issues jobs on group end or flush.
module a85_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  a85_pkg::in_item_t byte_item,
    output logic              byte_stall,
    output logic              job_push,
    output a85_pkg::job_t     job,
    input  logic              job_full
);

    logic [23:0] held_reg, held_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] padded;
    logic        accept;

    assign byte_stall = job_full;
    assign accept     = byte_valid && !job_full;

    always_comb
    begin
        case (count_reg)
            2'd1:    padded = {held_reg[7:0], 24'd0};
            2'd2:    padded = {held_reg[15:0], 16'd0};
            2'd3:    padded = {held_reg, 8'd0};
            default: padded = 32'd0;
        endcase
    end

    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        job_push   = 1'b0;
        job        = '0;
        if (accept)
        begin
            if (byte_item.operation == a85_pkg::OP_FLUSH)
            begin
                job_push      = 1'b1;
                job.value     = padded;
                job.has_group = (count_reg != 2'd0);
                job.has_nl    = 1'b1;
                held_next     = 24'd0;
                count_next    = 2'd0;
            end
            else if (count_reg == 2'd3)
            begin
                job_push      = 1'b1;
                job.value     = {held_reg, byte_item.data_byte};
                job.has_group = 1'b1;
                job.has_nl    = 1'b0;
                held_next     = 24'd0;
                count_next    = 2'd0;
            end
            else
            begin
                held_next  = {held_reg[15:0], byte_item.data_byte};
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 24'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/a85_fifo.sv]
// Short job queue between the front end and the digit unit.
module a85_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  a85_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output a85_pkg::job_t pop_job,
    output logic          valid
);

    localparam logic [a85_pkg::QPTR_W-1:0] PTR_LAST = a85_pkg::QPTR_W'(a85_pkg::QUEUE_DEPTH - 1);
    localparam logic [a85_pkg::QCNT_W-1:0] CNT_FULL = a85_pkg::QCNT_W'(a85_pkg::QUEUE_DEPTH);
    localparam logic [a85_pkg::QCNT_W-1:0] CNT_ONE  = a85_pkg::QCNT_W'(1);

    a85_pkg::job_t entry_reg [a85_pkg::QUEUE_DEPTH];
    logic [a85_pkg::QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [a85_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign valid   = (cnt_reg != '0);
    assign pop_job = entry_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

endmodule

[design/a85_conv.sv]
// Digit unit: splits a 32-bit group into five base-85 digits, one division a cycle.
module a85_conv (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  a85_pkg::job_t   job,
    output logic            job_pop,
    output logic            res_valid,
    output a85_pkg::group_t res,
    input  logic            res_pop
);

    localparam logic [2:0] LAST_STEP = 3'(a85_pkg::DIGITS - 1);

    logic            run_reg, run_next;
    logic [2:0]      step_reg, step_next;
    logic [31:0]     cur_reg, cur_next;
    logic [31:0]     prev_reg, prev_next;
    logic            group_reg, group_next;
    logic            nl_reg, nl_next;
    a85_pkg::digit_t [2:0] low_reg, low_next;
    logic            res_valid_reg, res_valid_next;
    a85_pkg::group_t res_reg, res_next;

    logic [63:0]     product;
    logic [13:0]     back_mul;
    a85_pkg::digit_t rem;
    logic            finish;
    logic [1:0]      low_idx;

    assign product  = 64'(cur_reg) * 64'(a85_pkg::DIV85_MAGIC);
    assign back_mul = 14'(cur_reg[6:0]) * 14'(a85_pkg::RADIX);
    // remainder is below 85, so the low seven bits of v - 85q carry it exactly
    assign rem      = prev_reg[6:0] - back_mul[6:0];
    assign low_idx  = step_reg[1:0] - 2'd1;

    assign finish    = run_reg && (step_reg == LAST_STEP) && (!res_valid_reg || res_pop);
    assign job_pop   = job_valid && (!run_reg || finish);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        run_next       = run_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        group_next     = group_reg;
        nl_next        = nl_reg;
        low_next       = low_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (run_reg && (step_reg != LAST_STEP))
        begin
            cur_next  = 32'(product >> a85_pkg::DIV85_SHIFT);
            prev_next = cur_reg;
            step_next = step_reg + 3'd1;
        end
        if (run_reg && (step_reg != 3'd0) && (step_reg != LAST_STEP))
        begin
            low_next[low_idx] = rem;
        end

        if (finish)
        begin
            res_valid_next     = 1'b1;
            res_next.digit[0]  = cur_reg[6:0];
            res_next.digit[1]  = rem;
            res_next.digit[2]  = low_reg[2];
            res_next.digit[3]  = low_reg[1];
            res_next.digit[4]  = low_reg[0];
            res_next.has_group = group_reg;
            res_next.has_nl    = nl_reg;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end

        if (job_pop)
        begin
            run_next   = 1'b1;
            cur_next   = job.value;
            group_next = job.has_group;
            nl_next    = job.has_nl;
            // newline-only job skips the divisions
            step_next  = job.has_group ? 3'd0 : LAST_STEP;
        end
        else if (finish)
        begin
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            step_reg      <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        group_reg <= group_next;
        nl_reg    <= nl_next;
        low_reg   <= low_next;
        res_reg   <= res_next;
    end

endmodule

[design/a85_emit.sv]
// Emitter: walks a converted group out one character a cycle, unless the receiver stalls, into the output register.
module a85_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  a85_pkg::group_t    res,
    output logic               res_pop,
    output logic               char_valid,
    output a85_pkg::out_item_t char_item,
    input  logic               char_stall
);

    logic [2:0]         pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    a85_pkg::out_item_t out_reg, out_next;
    logic               adv;
    logic               final_char;
    logic [6:0]         ch;

    assign adv        = res_valid && (!out_valid_reg || !char_stall);
    assign res_pop    = adv && final_char;
    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

    always_comb
    begin
        if (!res.has_group)
        begin
            final_char = 1'b1;
        end
        else if (res.has_nl)
        begin
            final_char = (pos_reg == 3'd5);
        end
        else
        begin
            final_char = (pos_reg == 3'd4);
        end
    end

    always_comb
    begin
        case (pos_reg)
            3'd0:    ch = res.digit[0] + a85_pkg::CHAR_OFFSET;
            3'd1:    ch = res.digit[1] + a85_pkg::CHAR_OFFSET;
            3'd2:    ch = res.digit[2] + a85_pkg::CHAR_OFFSET;
            3'd3:    ch = res.digit[3] + a85_pkg::CHAR_OFFSET;
            3'd4:    ch = res.digit[4] + a85_pkg::CHAR_OFFSET;
            default: ch = a85_pkg::NEWLINE;
        endcase
        if (!res.has_group)
        begin
            ch = a85_pkg::NEWLINE;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (adv)
        begin
            out_valid_next    = 1'b1;
            out_next.out_char = ch;
            out_next.last     = final_char;
            pos_next          = final_char ? 3'd0 : pos_reg + 3'd1;
        end
        else if (!char_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[design/ascii85_stream_encoder.sv]
// A byte that completes a group goes through the job queue and digit unit to the output.
// Throughput: one character per cycle unless the receiver stalls, set by the
// one-division-per-cycle digit unit and the one-character-per-cycle output register.
// A flush with held bytes emits a padded group and a newline, an empty flush only a newline;
// bytes enter one per cycle while the two-entry job queue has room.
// Reset (rst_n low, asynchronous) clears held bytes, queue, digit unit and output valid.
module ascii85_stream_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  a85_pkg::in_item_t  byte_item,
    output logic               byte_stall,
    output logic               char_valid,
    output a85_pkg::out_item_t char_item,
    input  logic               char_stall
);

    // Front end to queue
    logic            job_push;
    a85_pkg::job_t   job_in;
    logic            job_full;

    // Queue to digit unit
    logic            job_valid;
    a85_pkg::job_t   job_out;
    logic            job_pop;

    // Digit unit to emitter
    logic            res_valid;
    a85_pkg::group_t res;
    logic            res_pop;

    // Gather bytes; issue a job on a full group or a flush. Stall only when the queue is full.
    a85_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .byte_stall (byte_stall),
        .job_push   (job_push),
        .job        (job_in),
        .job_full   (job_full)
    );

    // Decouple intake from conversion so bytes keep flowing while a group is emitted.
    a85_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .full     (job_full),
        .pop      (job_pop),
        .pop_job  (job_out),
        .valid    (job_valid)
    );

    // Divide by 85 four times (reciprocal multiply), collect remainders into five digits.
    a85_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (res_pop)
    );

    // Emit digits most significant first, then the newline on flush; mark the last item.
    a85_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (res_pop),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_stall (char_stall)
    );

`ifndef SYNTH
    // Front end pushes only when it accepted an item, which never happens with the queue full.
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("job pushed into a full queue");

    // Emitter releases a converted group only while one is present.
    a_pop_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_pop |-> res_valid)
        else $error("converted group released while none present");

    // A newline always closes its item.
    a_newline_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && (char_item.out_char == a85_pkg::NEWLINE)) |-> char_item.last)
        else $error("newline without last");

    // Every character is a newline or an offset base-85 digit.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((char_item.out_char == a85_pkg::NEWLINE) ||
                        ((char_item.out_char >= a85_pkg::CHAR_OFFSET) &&
                         (char_item.out_char <= a85_pkg::CHAR_MAX))))
        else $error("character out of range");
`endif

endmodule

[tb/ascii85_stream_encoder_tb.sv]
// Self-checking testbench for the ASCII85 stream encoder: directed and random byte streams.
module ascii85_stream_encoder_tb;

    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 100000;
    localparam int ITEM_TARGET  = 170;
    localparam int GAP_PERCENT  = 9;
    localparam int TAIL_CYCLES  = 16;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               byte_valid;
    a85_pkg::in_item_t  byte_item;
    logic               byte_stall;
    logic               char_valid;
    a85_pkg::out_item_t char_item;
    logic               char_stall = 1'b0;

    // Predictor state: bytes gathered so far, newest in the low bits.
    logic [23:0] held_bytes;
    logic [1:0]  held_count;

    // Characters the encoder still owes us, oldest first.
    a85_pkg::out_item_t pending_chars[$];
    a85_pkg::out_item_t next_char;

    // Random idling switches for each side; cleared for the quiet stretch.
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;

    int cycle_count   = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int flushes_sent  = 0;
    int chars_checked = 0;

    ascii85_stream_encoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .byte_stall (byte_stall),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_stall (char_stall)
    );

    always #CLK_HALF clk = ~clk;

    // Queue the five characters of one 32-bit group, most significant digit first.
    function automatic void queue_group(logic [31:0] value, logic mark_last);
        logic [6:0]         digits [a85_pkg::DIGITS];
        logic [31:0]        rest;
        a85_pkg::out_item_t ch;
        rest = value;
        for (int i = a85_pkg::DIGITS - 1; i >= 0; i--)
        begin
            digits[i] = 7'(rest % a85_pkg::RADIX) + a85_pkg::CHAR_OFFSET;
            rest      = rest / a85_pkg::RADIX;
        end
        for (int i = 0; i < a85_pkg::DIGITS; i++)
        begin
            ch.out_char = digits[i];
            ch.last     = mark_last && (i == a85_pkg::DIGITS - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Advance the predictor by one accepted item and queue what it should produce.
    function automatic void encode_byte_item(a85_pkg::in_item_t it);
        logic [31:0]        padded;
        a85_pkg::out_item_t nl;
        if (it.operation == a85_pkg::OP_DATA)
        begin
            if (held_count == 2'd3)
            begin
                queue_group({held_bytes, it.data_byte}, 1'b1);
                held_bytes = '0;
                held_count = '0;
            end
            else
            begin
                held_bytes = {held_bytes[15:0], it.data_byte};
                held_count = held_count + 2'd1;
            end
        end
        else
        begin
            // Pad a partial group with zero bytes on the right, then close with a newline.
            if (held_count != 2'd0)
            begin
                padded = {8'h00, held_bytes} << (8 * (4 - held_count));
                queue_group(padded, 1'b0);
            end
            nl.out_char = a85_pkg::NEWLINE;
            nl.last     = 1'b1;
            pending_chars.push_back(nl);
            held_bytes = '0;
            held_count = '0;
        end
    endfunction

    // Offer one item, hold it until accepted, then update the prediction.
    task automatic send_item(logic op, logic [7:0] data);
        a85_pkg::in_item_t it;
        it.operation = op;
        it.data_byte = data;
        while (send_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        encode_byte_item(it);
        items_sent++;
        if (op == a85_pkg::OP_FLUSH) flushes_sent++;
    endtask

    task automatic send_data(logic [7:0] data);
        send_item(a85_pkg::OP_DATA, data);
    endtask

    // Flush carries a random byte that the encoder must ignore.
    task automatic send_flush();
        send_item(a85_pkg::OP_FLUSH, 8'($urandom_range(255)));
    endtask

    // Drop valid and wait for every owed character to come out.
    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
    endtask

    // Flushes with nothing held: a lone newline each.
    task automatic test_empty_flush();
        send_flush();
        send_flush();
    endtask

    // One, two and three bytes then a flush, at the extremes of the byte range.
    task automatic test_partial_groups();
        send_data(8'hFF);
        send_flush();
        send_data(8'h00);
        send_data(8'hFF);
        send_flush();
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'hFF);
        send_flush();
    endtask

    // Full groups: all zero, all ones and a mixed group, then a flush that finds nothing held.
    task automatic test_full_groups();
        repeat (4) send_data(8'h00);
        repeat (4) send_data(8'hFF);
        send_data(8'h80);
        send_data(8'h01);
        send_data(8'h7F);
        send_data(8'hFE);
        send_flush();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_quiet_burst();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (36) send_data(8'($urandom_range(255)));
        send_data(8'($urandom_range(255)));
        send_flush();
        wait_for_drain();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // Random streams of random length; most end in a flush, some run on into the next.
    task automatic test_random_streams();
        int len;
        int streams;
        logic [7:0] b;
        streams = 0;
        while (items_sent < ITEM_TARGET)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(13) : $urandom_range(5);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(5))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                send_data(b);
            end
            if ($urandom_range(7) != 0) send_flush();
            streams++;
            // Hold off now and then until the encoder has caught up.
            if (streams % 9 == 4) wait_for_drain();
        end
        send_flush();
    endtask

    // Check each accepted character against the oldest prediction; drive receiver stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d characters outstanding", $time,
                     pending_chars.size());
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && char_valid && !char_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual %h/%b", $time,
                         char_item.out_char, char_item.last);
                mismatches++;
            end
            else
            begin
                next_char = pending_chars.pop_front();
                if (char_item.out_char !== next_char.out_char)
                begin
                    $display("%0t: out_char mismatch: expected %h, actual %h", $time,
                             next_char.out_char, char_item.out_char);
                    mismatches++;
                end
                if (char_item.last !== next_char.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b", $time,
                             next_char.last, char_item.last);
                    mismatches++;
                end
                chars_checked++;
            end
        end
        char_stall <= recv_gaps && ($urandom_range(99) < GAP_PERCENT);
    end

    initial
    begin
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        held_bytes  = '0;
        held_count  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_flush();
        test_partial_groups();
        test_full_groups();
        test_quiet_burst();
        test_random_streams();

        // Let the last characters and any trailing activity settle.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time,
                     pending_chars.size());
            mismatches++;
        end

        $display("Covered %0d items (%0d flushes), %0d characters compared.",
                 items_sent, flushes_sent, chars_checked);
        $display("Streams included empty, partial and full groups with random stalls.");
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
